>>> hdl/gf16mac_pkg.sv
// ---------------------------------------------------------------------------
// gf16mac_pkg
// Types, constants and bit-level helpers shared by the GF(2^16) MAC block.
// ---------------------------------------------------------------------------
package gf16mac_pkg;

	localparam int WORD_W     = 16;
	localparam int PROD_W     = 2 * WORD_W - 1;   // unreduced carry-less product
	localparam int POLY_W     = 17;
	localparam int POLY_LOW_W = 5;
	localparam int COUNT_W    = 2;
	localparam int CFG_IDX_W  = 3;

	localparam logic [POLY_W-1:0]     POLY_FIXED     = 17'h11000;
	localparam logic [POLY_W-1:0]     POLY_FULL_MASK = 17'h1101f;
	localparam logic [POLY_LOW_W-1:0] POLY_LOW_RST   = 5'h0b;
	localparam logic [COUNT_W-1:0]    COUNT_RST      = 2'd1;

	// split point of the two reduction stages
	localparam int RED_SPLIT = 23;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY      = 3'd0,
		REG_COEF_A    = 3'd1,
		REG_COEF_B    = 3'd2,
		REG_COEF_C    = 3'd3,
		REG_SRC_COUNT = 3'd4,
		REG_MULT_ONLY = 3'd5
	} cfg_reg_t;

	// settings as the datapath uses them: unused sources already zeroed
	typedef struct packed {
		logic [POLY_LOW_W-1:0] poly_low;
		logic [WORD_W-1:0]     coef_a;
		logic [WORD_W-1:0]     coef_b;
		logic [WORD_W-1:0]     coef_c;
		logic                  acc_en;
	} mac_cfg_t;

	// carry-less 16x16 product
	function automatic logic [PROD_W-1:0] clmul(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [PROD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (b[i]) begin
				acc = acc ^ ({{(PROD_W-WORD_W){1'b0}}, a} << i);
			end
		end
		return acc;
	endfunction

	// clear bits hi..lo of v (descending) by XORing in shifted copies of the polynomial
	function automatic logic [PROD_W-1:0] reduce_range(input logic [PROD_W-1:0] v,
			input logic [POLY_LOW_W-1:0] poly_low, input int hi, input int lo);
		logic [PROD_W-1:0] r;
		logic [PROD_W-1:0] p;
		r = v;
		p = {{(PROD_W-POLY_W){1'b0}}, POLY_FIXED | {{(POLY_W-POLY_LOW_W){1'b0}}, poly_low}};
		for (int i = PROD_W - 1; i >= WORD_W; i--) begin
			if (i <= hi && i >= lo && r[i]) begin
				r = r ^ (p << (i - WORD_W));
			end
		end
		return r;
	endfunction

endpackage

>>> hdl/gf16mac_cfg.sv
// ---------------------------------------------------------------------------
// gf16mac_cfg
// Configuration registers; presents the effective settings to the datapath.
// ---------------------------------------------------------------------------
module gf16mac_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gf16mac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gf16mac_pkg::POLY_W-1:0]     cfg_data,
	output gf16mac_pkg::mac_cfg_t              cfg
);
	import gf16mac_pkg::*;

	logic [POLY_LOW_W-1:0] poly_low_q;
	logic [WORD_W-1:0]     coef_a_q;
	logic [WORD_W-1:0]     coef_b_q;
	logic [WORD_W-1:0]     coef_c_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  mult_only_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_low_q  <= POLY_LOW_RST;
			coef_a_q    <= '0;
			coef_b_q    <= '0;
			coef_c_q    <= '0;
			count_q     <= COUNT_RST;
			mult_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLY:      poly_low_q  <= cfg_data[POLY_LOW_W-1:0];
				REG_COEF_A:    coef_a_q    <= cfg_data[WORD_W-1:0];
				REG_COEF_B:    coef_b_q    <= cfg_data[WORD_W-1:0];
				REG_COEF_C:    coef_c_q    <= cfg_data[WORD_W-1:0];
				REG_SRC_COUNT: count_q     <= cfg_data[COUNT_W-1:0];
				REG_MULT_ONLY: mult_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// count of zero acts as one; multiply-only drops acc and the other sources
	always_comb begin
		cfg.poly_low = poly_low_q;
		cfg.coef_a   = coef_a_q;
		cfg.coef_b   = (!mult_only_q && count_q >= 2'd2) ? coef_b_q : '0;
		cfg.coef_c   = (!mult_only_q && count_q == 2'd3) ? coef_c_q : '0;
		cfg.acc_en   = !mult_only_q;
	end

endmodule

>>> hdl/gf16mac_pipe.sv
// ---------------------------------------------------------------------------
// gf16mac_pipe
// Three-stage datapath: carry-less products, combine and upper reduction,
// lower reduction into the output register.
// ---------------------------------------------------------------------------
module gf16mac_pipe (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gf16mac_pkg::mac_cfg_t           cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [gf16mac_pkg::WORD_W-1:0]  acc_word,
	input  logic [gf16mac_pkg::WORD_W-1:0]  src_a,
	input  logic [gf16mac_pkg::WORD_W-1:0]  src_b,
	input  logic [gf16mac_pkg::WORD_W-1:0]  src_c,
	input  logic                            last_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gf16mac_pkg::WORD_W-1:0]  result_word,
	output logic                            last_out
);
	import gf16mac_pkg::*;

	logic                 vld_s1, vld_s2, vld_s3;
	logic                 en1, en2, en3;
	logic [PROD_W-1:0]    pa_s1, pb_s1, pc_s1;
	logic [WORD_W-1:0]    acc_s1;
	logic                 last_s1, last_s2, last_s3;
	logic [RED_SPLIT-1:0] part_s2;
	logic [WORD_W-1:0]    res_s3;
	logic [PROD_W-1:0]    sum2, red2, red3;

	// a stage loads when it is empty or its contents move on this cycle
	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			pa_s1   <= clmul(src_a, cfg.coef_a);
			pb_s1   <= clmul(src_b, cfg.coef_b);
			pc_s1   <= clmul(src_c, cfg.coef_c);
			acc_s1  <= cfg.acc_en ? acc_word : '0;
			last_s1 <= last_in;
		end
	end

	// reduction is linear, so sum first and reduce once
	assign sum2 = pa_s1 ^ pb_s1 ^ pc_s1 ^ {{(PROD_W-WORD_W){1'b0}}, acc_s1};
	assign red2 = reduce_range(sum2, cfg.poly_low, PROD_W - 1, RED_SPLIT);

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			part_s2 <= red2[RED_SPLIT-1:0];
			last_s2 <= last_s1;
		end
	end

	assign red3 = reduce_range({{(PROD_W-RED_SPLIT){1'b0}}, part_s2}, cfg.poly_low,
		RED_SPLIT - 1, WORD_W);

	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			res_s3  <= red3[WORD_W-1:0];
			last_s3 <= last_s2;
		end
	end

	assign out_valid   = vld_s3;
	assign result_word = res_s3;
	assign last_out    = last_s3;

endmodule

>>> hdl/gf16_multiply_accumulate_core.sv
// ---------------------------------------------------------------------------
// gf16_multiply_accumulate_core
// GF(2^16) multiply-accumulate: acc ^ a*ca ^ b*cb ^ c*cc, or a*ca alone.
//
//   channel   handshake               payload
//   input     in_valid / in_ready     acc_word, src_a, src_b, src_c, last_in
//   output    out_valid / out_ready   result_word, last_out
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready is high; beats pass through the product,
// upper-reduction and lower-reduction stages, the last being the output register.
// Stages advance independently, so bubbles close up while the output is stalled.
// cfg_ready is always high. Reset clears the stage valids and loads register defaults.
// ---------------------------------------------------------------------------
module gf16_multiply_accumulate_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gf16mac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gf16mac_pkg::POLY_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [gf16mac_pkg::WORD_W-1:0]     acc_word,
	input  logic [gf16mac_pkg::WORD_W-1:0]     src_a,
	input  logic [gf16mac_pkg::WORD_W-1:0]     src_b,
	input  logic [gf16mac_pkg::WORD_W-1:0]     src_c,
	input  logic                               last_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [gf16mac_pkg::WORD_W-1:0]     result_word,
	output logic                               last_out
);
	import gf16mac_pkg::*;

	mac_cfg_t cfg;

	gf16mac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gf16mac_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.acc_word    (acc_word),
		.src_a       (src_a),
		.src_b       (src_b),
		.src_c       (src_c),
		.last_in     (last_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_word (result_word),
		.last_out    (last_out)
	);

endmodule

>>> hdl/gf16mac_checker.sv
// ---------------------------------------------------------------------------
// gf16mac_checker
// Port-level checks on stall behavior and pipeline latency.
// ---------------------------------------------------------------------------
module gf16mac_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [gf16mac_pkg::WORD_W-1:0]     result_word,
	input logic                               last_out
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_word) && $stable(last_out))
		else $error("output beat changed while stalled");

	// draining output means the whole pipe can move
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// an empty output stage never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output stage");

	// beat reaches the output when not back-pressured
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted beat did not reach the output");

endmodule

bind gf16_multiply_accumulate_core gf16mac_checker u_checker (.*);
